[sv/assert_macros.svh]
// Assertion macros shared by the resampler RTL.
// Depends on nothing; SYNTH builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ZSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("zsr assertion failed");
`define ZSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("zsr assertion failed");
`else
`define ZSR_ASSERT(lbl, clk, rst_n, prop)
`define ZSR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/zsr_pkg.sv]
// Shared widths, register indexes and controller/datapath command types
// for the zoom/shift resampler. No dependencies.
package zsr_pkg;

  localparam int PIX_W  = 16;  // pixel port width
  localparam int POS_W  = 8;   // row / col port width
  localparam int SZ_W   = 9;   // frame size register width
  localparam int ZM_W   = 10;  // zoom / shift register width
  localparam int SC_W   = 20;  // scaled frame size width
  localparam int NUM_W  = 21;  // signed mapped position width
  localparam int PROD_W = 28;  // dividend width
  localparam int MAP_W  = NUM_W - 1 + SZ_W;
  localparam int IDX_W  = 3;   // config index width

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [IDX_W-1:0] REG_ZOOM_AMOUNT  = 3'd2;
  localparam logic [IDX_W-1:0] REG_SHIFT_X      = 3'd3;
  localparam logic [IDX_W-1:0] REG_SHIFT_Y      = 3'd4;

  localparam logic [SZ_W-1:0] SIZE_RST = 9'd256;

  typedef struct packed {
    logic store_en;     // write the incoming pixel
    logic load_req;     // capture a fetch position
    logic cfg_we;       // register write
    logic derive;       // divider operands come from the size derivation
    logic drv_base_en;  // write the zoomed side
    logic drv_end_en;   // write the ratio-scaled side
    logic div_start;    // load and launch the divider
    logic num_en;       // register the shifted position
    logic axis;         // 0 column, 1 row
    logic clip_en;      // clip quotient into source coordinate
    logic rd_en;        // read the pixel store
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

endpackage

[sv/zsr_div.sv]
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// Depends on zsr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module zsr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [zsr_pkg::PROD_W-1:0] num,
  input  logic [zsr_pkg::SC_W-1:0]   den,
  output logic [zsr_pkg::PROD_W-1:0] quo,
  output logic                       done
);
  import zsr_pkg::*;

  localparam int CNT_W = $clog2(PROD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(PROD_W - 1);

  logic [SC_W-1:0]   rem_r, rem_nxt;
  logic [PROD_W-1:0] quo_r, quo_nxt;
  logic [SC_W-1:0]   den_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              run_r;
  logic              done_r;
  logic [SC_W:0]     trial;
  logic [SC_W:0]     trial_diff;
  logic              fits;

  assign trial      = {rem_r, quo_r[PROD_W-1]};
  assign trial_diff = trial - {1'b0, den_r};
  assign fits       = (trial >= {1'b0, den_r});
  assign rem_nxt    = fits ? trial_diff[SC_W-1:0] : trial[SC_W-1:0];
  assign quo_nxt    = {quo_r[PROD_W-2:0], fits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= num;
      den_r <= den;
    end else if (run_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

  `ZSR_ASSERT(a_done_ends_run, clk, rst_n, done_r |-> !run_r)
  `ZSR_ASSERT_NEXT(a_start_runs, clk, rst_n, start && rst_n, run_r && cnt_r == '0)

endmodule

[sv/zsr_ctrl.sv]
// Sequencer for the resampler: store write, size derivation, two divider passes per fetch, store read.
// Depends on zsr_pkg and assert_macros.svh.
`include "assert_macros.svh"
module zsr_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_func,
  input  logic          cfg_valid,
  output logic          busy,
  output logic          cfg_ready,
  output zsr_pkg::cmd_t cmd,
  input  zsr_pkg::sts_t sts
);
  import zsr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_DRV_MUL = 7'b0000010,
    S_DRV_DIV = 7'b0000100,
    S_NUM     = 7'b0001000,
    S_MUL     = 7'b0010000,
    S_DIV     = 7'b0100000,
    S_READ    = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   axis_r, axis_nxt;
  logic   idle;

  assign idle      = (state_r == S_IDLE);
  assign busy      = !idle;
  assign cfg_ready = idle && !start;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    axis_nxt  = axis_r;
    cmd.axis  = axis_r;
    unique case (state_r)
      S_IDLE: begin
        cmd.store_en = start && !in_func;
        cmd.load_req = start && in_func;
        cmd.cfg_we   = cfg_valid && !start;
        if (start && in_func) begin
          state_nxt = S_NUM;
          axis_nxt  = 1'b0;
        end else if (cfg_valid && !start) begin
          state_nxt = S_DRV_MUL;
        end
      end
      S_DRV_MUL: begin
        cmd.derive      = 1'b1;
        cmd.drv_base_en = 1'b1;
        cmd.div_start   = 1'b1;
        state_nxt       = S_DRV_DIV;
      end
      S_DRV_DIV: begin
        cmd.derive = 1'b1;
        if (sts.div_done) begin
          cmd.drv_end_en = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      S_NUM: begin
        cmd.num_en = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.clip_en = 1'b1;
          if (axis_r) begin
            state_nxt = S_READ;
          end else begin
            state_nxt = S_NUM;
            axis_nxt  = 1'b1;
          end
        end
      end
      S_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_DRV_MUL;
      axis_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      axis_r  <= axis_nxt;
    end
  end

  `ZSR_ASSERT(a_done_in_div, clk, rst_n, sts.div_done |-> (state_r == S_DIV || state_r == S_DRV_DIV))
  `ZSR_ASSERT_NEXT(a_fetch_starts_col, clk, rst_n, cmd.load_req, state_r == S_NUM && !axis_r)

endmodule

[sv/zsr_dp.sv]
// Resampler datapath: config and scaled-size registers, coordinate mapping,
// pixel store and result registers. Depends on zsr_pkg, zsr_div, assert_macros.svh.
`include "assert_macros.svh"
module zsr_dp #(
  parameter int MAX_DIM    = 256,
  parameter int PIXEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  zsr_pkg::cmd_t             cmd,
  output zsr_pkg::sts_t             sts,
  input  logic [zsr_pkg::POS_W-1:0] in_row,
  input  logic [zsr_pkg::POS_W-1:0] in_col,
  input  logic [zsr_pkg::PIX_W-1:0] in_pixel_in,
  input  logic [zsr_pkg::IDX_W-1:0] cfg_index,
  input  logic [zsr_pkg::ZM_W-1:0]  cfg_data,
  output logic                      out_strobe,
  output logic [zsr_pkg::PIX_W-1:0] out_pixel_out,
  output logic [zsr_pkg::POS_W-1:0] out_src_row,
  output logic [zsr_pkg::POS_W-1:0] out_src_col
);
  import zsr_pkg::*;

  localparam int CB    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = 2 * CB;
  localparam int DIM_W = 13;
  localparam logic [DIM_W-1:0] MAXD = DIM_W'(MAX_DIM);

  function automatic logic [SZ_W-1:0] eff_size(input logic [SZ_W-1:0] r);
    logic [SZ_W-1:0] v;
    if (r == '0) begin
      v = SZ_W'(1);
    end else if ({{(DIM_W-SZ_W){1'b0}}, r} > MAXD) begin
      v = MAXD[SZ_W-1:0];
    end else begin
      v = r;
    end
    return v;
  endfunction

  // configuration registers
  logic [SZ_W-1:0]        cfg_w_r, cfg_h_r;
  logic signed [ZM_W-1:0] zoom_r, shx_r, shy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= SIZE_RST;
      cfg_h_r <= SIZE_RST;
      zoom_r  <= '0;
      shx_r   <= '0;
      shy_r   <= '0;
    end else if (cmd.cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  cfg_w_r <= cfg_data[SZ_W-1:0];
        REG_FRAME_HEIGHT: cfg_h_r <= cfg_data[SZ_W-1:0];
        REG_ZOOM_AMOUNT:  zoom_r  <= cfg_data;
        REG_SHIFT_X:      shx_r   <= cfg_data;
        REG_SHIFT_Y:      shy_r   <= cfg_data;
        default:          ;
      endcase
    end
  end

  logic [SZ_W-1:0] w_eff, h_eff;
  assign w_eff = eff_size(cfg_w_r);
  assign h_eff = eff_size(cfg_h_r);

  // scaled size derivation: zoom the shorter side, scale the other by ratio
  logic                   h_lt_w;
  logic [SZ_W-1:0]        side, other;
  logic signed [ZM_W:0]   base_sum;
  logic [ZM_W-1:0]        base;
  logic [SZ_W+ZM_W-1:0]   drv_prod;
  logic [SC_W-1:0]        sw_r, sh_r;
  logic [SC_W-1:0]        drv_val;
  logic [PROD_W-1:0]      quo;

  assign h_lt_w   = (h_eff < w_eff);
  assign side     = h_lt_w ? h_eff : w_eff;
  assign other    = h_lt_w ? w_eff : h_eff;
  assign base_sum = $signed({2'b00, side}) + $signed({zoom_r[ZM_W-1], zoom_r});
  assign base     = (base_sum < 1) ? ZM_W'(1) : base_sum[ZM_W-1:0];
  assign drv_prod = other * base;
  assign drv_val  = (quo[SC_W-1:0] == '0) ? SC_W'(1) : quo[SC_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.drv_base_en) begin
      if (h_lt_w) begin
        sh_r <= SC_W'(base);
      end else begin
        sw_r <= SC_W'(base);
      end
    end else if (cmd.drv_end_en) begin
      if (h_lt_w) begin
        sw_r <= drv_val;
      end else begin
        sh_r <= drv_val;
      end
    end
  end

  // fetch mapping, one axis at a time
  logic [POS_W-1:0]        req_row_r, req_col_r;
  logic [POS_W-1:0]        pos;
  logic [SZ_W-1:0]         size;
  logic [SC_W-1:0]         scaled;
  logic signed [ZM_W-1:0]  shift;
  logic signed [NUM_W-1:0] diff, half, num_nxt, num_r;
  logic [MAP_W-1:0]        map_full;
  logic [PROD_W-1:0]       map_prod;
  logic [PROD_W-1:0]       div_num;
  logic [SC_W-1:0]         div_den;
  logic                    div_done;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_row_r <= in_row;
      req_col_r <= in_col;
    end
  end

  assign pos    = cmd.axis ? req_row_r : req_col_r;
  assign size   = cmd.axis ? h_eff : w_eff;
  assign scaled = cmd.axis ? sh_r : sw_r;
  assign shift  = cmd.axis ? shy_r : shx_r;

  // half growth, truncated toward zero
  assign diff    = $signed({1'b0, scaled}) - $signed({{(NUM_W-SZ_W){1'b0}}, size});
  assign half    = (diff + $signed({{(NUM_W-1){1'b0}}, diff[NUM_W-1]})) >>> 1;
  assign num_nxt = $signed({{(NUM_W-POS_W){1'b0}}, pos}) + half - NUM_W'(shift);

  always_ff @(posedge clk) begin
    if (cmd.num_en) begin
      num_r <= num_nxt;
    end
  end

  // negative position maps to a non-positive quotient: feed zero, clips to 0
  assign map_full = num_r[NUM_W-2:0] * size;
  assign map_prod = num_r[NUM_W-1] ? '0 : map_full[PROD_W-1:0];

  assign div_num = cmd.derive ? PROD_W'(drv_prod) : map_prod;
  assign div_den = cmd.derive ? SC_W'(side) : scaled;

  zsr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .quo   (quo),
    .done  (div_done)
  );

  assign sts = '{div_done: div_done};

  // clip into the frame
  logic [SZ_W-1:0] clip_val;
  logic [SZ_W-1:0] src_row_r, src_col_r;

  assign clip_val = (quo >= PROD_W'(size)) ? size - SZ_W'(1) : quo[SZ_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.clip_en) begin
      if (cmd.axis) begin
        src_row_r <= clip_val;
      end else begin
        src_col_r <= clip_val;
      end
    end
  end

  // pixel store
  logic [PIXEL_BITS-1:0] mem [0:(2**AW)-1];
  logic [PIXEL_BITS-1:0] rd_data_r;
  logic                  store_ok;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic                  out_valid_r;

  assign store_ok = cmd.store_en
                  && ({{(DIM_W-POS_W){1'b0}}, in_row} < MAXD)
                  && ({{(DIM_W-POS_W){1'b0}}, in_col} < MAXD);
  assign wr_addr  = {CB'(in_row), CB'(in_col)};
  assign rd_addr  = {CB'(src_row_r), CB'(src_col_r)};

  always_ff @(posedge clk) begin
    if (store_ok) begin
      mem[wr_addr] <= in_pixel_in[PIXEL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rd_en;
    end
  end

  assign out_strobe    = out_valid_r;
  assign out_pixel_out = PIX_W'(rd_data_r);
  assign out_src_row   = src_row_r[POS_W-1:0];
  assign out_src_col   = src_col_r[POS_W-1:0];

  `ZSR_ASSERT(a_col_in_frame, clk, rst_n, out_valid_r |-> src_col_r < w_eff)
  `ZSR_ASSERT(a_row_in_frame, clk, rst_n, out_valid_r |-> src_row_r < h_eff)

endmodule

[sv/zoom_shift_nearest_resampler_unit.sv]
// Nearest-neighbor zoom/shift resampler top level: zsr_ctrl sequencer plus zsr_dp datapath.
// Store beat: no result, back to back. Fetch beat: result strobe in the same cycle that busy
//   goes low, after two 28-step passes of the shared radix-2 divider, and only then is a new
//   fetch taken. Results stay only until the next fetch overwrites them: take them on the strobe.
// Config write: busy while scaled sizes are rederived on the same divider.
// Reset: synchronous, active low; busy after release while scaled sizes are rederived, pixel store not cleared.
module zoom_shift_nearest_resampler_unit #(
  parameter int MAX_DIM    = 256,
  parameter int PIXEL_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  // command channel
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_func,
  input  logic [zsr_pkg::POS_W-1:0] in_row,
  input  logic [zsr_pkg::POS_W-1:0] in_col,
  input  logic [zsr_pkg::PIX_W-1:0] in_pixel_in,
  // result channel
  output logic                      out_strobe,
  output logic [zsr_pkg::PIX_W-1:0] out_pixel_out,
  output logic [zsr_pkg::POS_W-1:0] out_src_row,
  output logic [zsr_pkg::POS_W-1:0] out_src_col,
  // register write channel
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [zsr_pkg::IDX_W-1:0] cfg_index,
  input  logic [zsr_pkg::ZM_W-1:0]  cfg_data
);
  import zsr_pkg::*;

  // Control flow:
  //  - A store beat writes the pixel straight into the store at the accept edge;
  //    rows or columns at or beyond MAX_DIM are dropped.
  //  - A fetch beat maps the column, then the row: register the shifted position,
  //    multiply by the frame size into the divider, divide by the scaled size,
  //    clip into the frame. Then read the store and raise the strobe for one cycle.
  //  - A register write rederives the scaled frame: zoom the shorter side, then
  //    divide to scale the other side by the same ratio.
  //  - Register writes are taken only while idle and no start is present.
  cmd_t cmd;
  sts_t sts;

  zsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_func   (in_func),
    .cfg_valid (cfg_valid),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  zsr_dp #(
    .MAX_DIM    (MAX_DIM),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_pixel_in   (in_pixel_in),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_strobe    (out_strobe),
    .out_pixel_out (out_pixel_out),
    .out_src_row   (out_src_row),
    .out_src_col   (out_src_col)
  );

endmodule
